// ===== sv/button_debounce_press_classifier_assert.svh =====
// assertion macros shared by the classifier rtl
`ifndef BUTTON_DEBOUNCE_PRESS_CLASSIFIER_ASSERT_SVH
`define BUTTON_DEBOUNCE_PRESS_CLASSIFIER_ASSERT_SVH

// condition in this cycle implies consequence in the same cycle
`define BDPC_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition in this cycle implies consequence in the next cycle
`define BDPC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/bdpc_pkg.sv =====
`timescale 1ns / 1ps

package bdpc_pkg;

  localparam int BUTTON_COUNT = 5;
  localparam int PIN_W        = 5;
  localparam int ACT_W        = 2 * PIN_W;
  localparam int IDX_W        = 3;
  localparam int SETTLE_W     = 10;
  localparam int HOLD_W       = 16;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_IDX_W    = 2;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ACT_NONE      = 2'd0,
    ACT_SHORT     = 2'd1,
    ACT_LONG      = 2'd2,
    ACT_VERY_LONG = 2'd3
  } act_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE_TICKS  = 2'd0,
    REG_LONG_TICKS      = 2'd1,
    REG_VERY_LONG_TICKS = 2'd2,
    REG_PRESSED_LEVEL   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [SETTLE_W-1:0] debounce_ticks;
    logic [HOLD_W-1:0]   long_press_ticks;
    logic [HOLD_W-1:0]   very_long_press_ticks;
    logic                pressed_level;
  } cfg_t;

  typedef struct packed {
    logic pressed;
    act_t action;
  } btn_stat_t;

endpackage

// ===== sv/bdpc_button.sv =====
`timescale 1ns / 1ps

module bdpc_button import bdpc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  cmd_t      cmd,
  input  logic      pin,
  input  cfg_t      cfg,
  output btn_stat_t stat,
  output btn_stat_t stat_nxt
);

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_UP    = 2'd1,
    PH_WAIT  = 2'd2,
    PH_DOWN  = 2'd3
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [SETTLE_W-1:0] settle_r, settle_nxt;
  logic                await_r, await_nxt;
  logic [HOLD_W-1:0]   hold_r, hold_nxt;
  act_t                act_r, act_nxt;
  logic                down;

  assign down = (pin == cfg.pressed_level);

  always_comb begin
    phase_nxt  = phase_r;
    settle_nxt = settle_r;
    await_nxt  = await_r;
    hold_nxt   = hold_r;
    act_nxt    = act_r;
    if (step) begin
      unique case (cmd)
        CMD_SAMPLE: begin
          unique case (phase_r)
            PH_START: begin
              if (!down) phase_nxt = PH_UP;
            end
            PH_UP: begin
              if (down) begin
                phase_nxt  = PH_WAIT;
                settle_nxt = '0;
              end
            end
            PH_WAIT: begin
              // a count above a lowered limit still counts as settled
              if (settle_r >= cfg.debounce_ticks) phase_nxt = down ? PH_DOWN : PH_UP;
            end
            PH_DOWN: begin
              if (!down) begin
                phase_nxt  = PH_WAIT;
                settle_nxt = '0;
              end
            end
            default: phase_nxt = phase_r;
          endcase
          // classification sees the phase after this sample
          if (act_r == ACT_NONE) begin
            if (!await_r) begin
              if (phase_nxt == PH_DOWN) await_nxt = 1'b1;
            end else if (phase_nxt == PH_UP) begin
              await_nxt = 1'b0;
              if (hold_r >= cfg.very_long_press_ticks) act_nxt = ACT_VERY_LONG;
              else if (hold_r >= cfg.long_press_ticks) act_nxt = ACT_LONG;
              else act_nxt = ACT_SHORT;
            end
          end
        end
        CMD_TICK: begin
          if (settle_r < cfg.debounce_ticks) settle_nxt = settle_r + 1'b1;
          if (await_r) begin
            if (hold_r != '1) hold_nxt = hold_r + 1'b1;
          end else begin
            hold_nxt = '0;
          end
        end
        CMD_CLEAR: act_nxt = ACT_NONE;
        CMD_QUERY: act_nxt = act_r;
        default:   act_nxt = act_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_START;
      settle_r <= '0;
      await_r  <= 1'b0;
      hold_r   <= '0;
      act_r    <= ACT_NONE;
    end else begin
      phase_r  <= phase_nxt;
      settle_r <= settle_nxt;
      await_r  <= await_nxt;
      hold_r   <= hold_nxt;
      act_r    <= act_nxt;
    end
  end

  assign stat.pressed     = (phase_r == PH_DOWN);
  assign stat.action      = act_r;
  assign stat_nxt.pressed = (phase_nxt == PH_DOWN);
  assign stat_nxt.action  = act_nxt;

endmodule

// ===== sv/button_debounce_press_classifier.sv =====
// Debounces five buttons and classifies each finished press as short, long or
// very long by two hold thresholds; a latched action stays until a clear command.
// One command is taken every clock cycle unless a stalled result blocks it.
// An item passes an input register, where the per-button state is updated, and
// then a result register, which offers its result; a stalled result holds the input
// register and a new command is taken in the same cycle the result register drains.
`timescale 1ns / 1ps

`include "button_debounce_press_classifier_assert.svh"

module button_debounce_press_classifier import bdpc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_command,
  input  logic [PIN_W-1:0]      in_pin_levels,
  input  logic [IDX_W-1:0]      in_button_index,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ACT_W-1:0]      out_actions,
  output logic [1:0]            out_selected_action,
  output logic [PIN_W-1:0]      out_debounced_pressed,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t              cfg_r;
  logic              s1_valid_r;
  cmd_t              s1_cmd_r;
  logic [PIN_W-1:0]  s1_pins_r;
  logic [IDX_W-1:0]  s1_idx_r;
  logic              s1_advance;
  logic              out_valid_r;
  logic [ACT_W-1:0]  actions_r, actions_nxt;
  act_t              sel_r, sel_nxt;
  logic [PIN_W-1:0]  pressed_r, pressed_nxt, pressed_cur;
  btn_stat_t         stat [BUTTON_COUNT];
  btn_stat_t         stat_nxt [BUTTON_COUNT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks        <= SETTLE_W'(50);
      cfg_r.long_press_ticks      <= HOLD_W'(1000);
      cfg_r.very_long_press_ticks <= HOLD_W'(3000);
      cfg_r.pressed_level         <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_DEBOUNCE_TICKS:  cfg_r.debounce_ticks        <= cfg_wdata[SETTLE_W-1:0];
        REG_LONG_TICKS:      cfg_r.long_press_ticks      <= cfg_wdata[HOLD_W-1:0];
        REG_VERY_LONG_TICKS: cfg_r.very_long_press_ticks <= cfg_wdata[HOLD_W-1:0];
        REG_PRESSED_LEVEL:   cfg_r.pressed_level         <= cfg_wdata[0];
        default:             cfg_r <= cfg_r;
      endcase
    end
  end

  assign s1_advance = !out_valid_r || out_ready;
  assign in_ready   = !s1_valid_r || s1_advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cmd_r  <= cmd_t'(in_command);
      s1_pins_r <= in_pin_levels;
      s1_idx_r  <= in_button_index;
    end
  end

  for (genvar i = 0; i < BUTTON_COUNT; i++) begin : g_btn
    bdpc_button u_button (
      .clk      (clk),
      .rst_n    (rst_n),
      .step     (s1_valid_r && s1_advance),
      .cmd      (s1_cmd_r),
      .pin      (s1_pins_r[i]),
      .cfg      (cfg_r),
      .stat     (stat[i]),
      .stat_nxt (stat_nxt[i])
    );
    assign actions_nxt[2*i +: 2] = stat_nxt[i].action;
    assign pressed_nxt[i]        = stat_nxt[i].pressed;
    assign pressed_cur[i]        = stat[i].pressed;
  end

  always_comb begin
    sel_nxt = ACT_NONE;
    if (s1_idx_r < IDX_W'(BUTTON_COUNT)) sel_nxt = stat_nxt[s1_idx_r].action;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_advance) begin
      actions_r <= actions_nxt;
      sel_r     <= sel_nxt;
      pressed_r <= pressed_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_actions           = actions_r;
  assign out_selected_action   = sel_r;
  assign out_debounced_pressed = pressed_r;

  `BDPC_ASSERT_NEXT(a_clear_empties,
    s1_valid_r && s1_advance && s1_cmd_r == CMD_CLEAR,
    out_actions == '0 && out_selected_action == ACT_NONE,
    "clear left an action latched")
  `BDPC_ASSERT_NEXT(a_stall_holds_item, s1_valid_r && !s1_advance, s1_valid_r,
    "input stage dropped an item during output stall")
  `BDPC_ASSERT_NEXT(a_pressed_only_on_sample,
    !(s1_valid_r && s1_advance && s1_cmd_r == CMD_SAMPLE), $stable(pressed_cur),
    "debounced level changed without a sample")
  `BDPC_ASSERT_SAME(a_selected_in_actions,
    out_valid_r && out_selected_action != ACT_NONE, out_actions != '0,
    "selected action missing from action vector")

endmodule
